>>> rtl/core/ucdp_pkg.sv
// Shared types and constants of the configuration descriptor parser.
// Used by the parser front, the record queue, the output stage and the top.
// No dependencies.
package ucdp_pkg;

   // channel widths
   localparam int ReqDataW = 24;
   localparam int RspDataW = 88;

   // descriptor scratch bytes and record queue size
   localparam int DescBytes   = 9;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   // descriptor type codes
   localparam logic [7:0] DT_CONFIG    = 8'd2;
   localparam logic [7:0] DT_INTERFACE = 8'd4;
   localparam logic [7:0] DT_ENDPOINT  = 8'd5;

   // minimum lengths and bit masks
   localparam logic [7:0] MinLenLong     = 8'd9;
   localparam logic [7:0] MinLenEndpoint = 8'd7;
   localparam logic [7:0] MinLenAny      = 8'd2;
   localparam logic [7:0] SelfPoweredBit = 8'h40;
   localparam logic [7:0] XferTypeMask   = 8'h03;

   typedef enum logic [2:0] {
      KIND_CONFIG    = 3'd0,
      KIND_INTERFACE = 3'd1,
      KIND_ENDPOINT  = 3'd2,
      KIND_OTHER     = 3'd3,
      KIND_DONE      = 3'd4,
      KIND_ERROR     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_HEADER = 3'd1,
      ERR_TRUNCATED  = 3'd2,
      ERR_BAD_LENGTH = 3'd3,
      ERR_TOO_SHORT  = 3'd4
   } err_type;

   // one decoded result record
   typedef struct packed {
      kind_type    kind;
      err_type     code;
      logic [7:0]  dtype;
      logic [7:0]  dlen;
      logic [15:0] offset;
      logic [7:0]  val_a;
      logic [7:0]  val_b;
      logic [15:0] val_c;
      logic [7:0]  val_d;
      logic [7:0]  val_e;
      logic        dir_in;
   } rec_type;

   // all records caused by one input byte (one or two)
   typedef struct packed {
      logic    two;
      rec_type first;
      rec_type second;
   } pair_type;

   // queue status seen by the front and the top
   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QueueCntW-1:0] count;
   } qstat_type;

endpackage

>>> rtl/core/usb_config_descriptor_parser.sv
// USB configuration descriptor parser, top level.
// Depends on ucdp_pkg, ucdp_front, ucdp_queue and ucdp_back.
//
// Usage:
//   req_*: one word per blob byte: data byte and blob length in tdata,
//   tlast on the final byte of the blob. After that byte the parser starts
//   over at offset 0 for the next blob.
//   rsp_*: one word per decoded record (configuration, interface,
//   endpoint, other, done or error). The record kind is in tuser; tlast
//   marks the final record caused by one input byte.
// Timing:
//   A record passes through the record queue and the output register
//   before it appears on rsp. Bytes that cause zero or one record are taken
//   one per cycle while the record queue is not full. A byte that causes two
//   records holds the single-word output register for both of its words, so
//   a long run of such bytes is paced by that register. A four-entry record
//   queue lets the front keep taking bytes while the output side is stalled;
//   req_tready drops only when that queue is full.
// Reset:
//   Clears the parser (awaiting a header at offset 0), the queue and the
//   output register. Held rsp words stay stable while rsp_tready is low.
module usb_config_descriptor_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [7:0] data_byte, [23:8] blob_length
   input  logic [ucdp_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] error_code, [10:3] desc_type, [18:11] desc_length,
   // [34:19] desc_offset, [42:35] value_a, [50:43] value_b,
   // [66:51] value_c, [74:67] value_d, [82:75] value_e,
   // [83] direction_in, [87:84] zero
   output logic [ucdp_pkg::RspDataW-1:0] rsp_tdata,
   // [2:0] record_kind
   output logic [2:0]                    rsp_tuser,
   output logic                          rsp_tlast
);
   import ucdp_pkg::*;

   logic      push;
   pair_type  push_pair;
   logic      pop;
   pair_type  head;
   qstat_type q_stat;
   rec_type   out_rec;

   ucdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata[7:0]),
      .in_blob   (req_tdata[23:8]),
      .in_last   (req_tlast),
      .q_stat    (q_stat),
      .push      (push),
      .push_pair (push_pair)
   );

   ucdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pair (push_pair),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   ucdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_stat.empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec),
      .out_last  (rsp_tlast)
   );

   // pack the record onto the result word
   assign rsp_tuser = out_rec.kind;
   assign rsp_tdata = {4'd0, out_rec.dir_in, out_rec.val_e, out_rec.val_d,
                       out_rec.val_c, out_rec.val_b, out_rec.val_a,
                       out_rec.offset, out_rec.dlen, out_rec.dtype,
                       out_rec.code};

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QueueCntW'(QueueDepth))
      else $error("record queue count above depth");

   // a push is never offered while the queue is full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("record push while queue full");

   // error records carry a code
   a_error_coded: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_rec.kind == KIND_ERROR) |-> out_rec.code != ERR_NONE)
      else $error("error record without code");

   // other records carry no code
   a_plain_uncoded: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_rec.kind != KIND_ERROR) |-> out_rec.code == ERR_NONE)
      else $error("non-error record with error code");

endmodule

>>> rtl/core/ucdp_front.sv
// Parser front: accepts blob bytes, tracks header and descriptor chain,
// and builds the zero, one or two records each byte causes. Depends on ucdp_pkg.
module ucdp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic [15:0]       in_blob,
   input  logic              in_last,
   input  ucdp_pkg::qstat_type q_stat,
   output logic              push,
   output ucdp_pkg::pair_type push_pair
);
   import ucdp_pkg::*;

   typedef enum logic [1:0] {
      PH_PARSE = 2'b01,
      PH_IDLE  = 2'b10
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  bytes_ff [DescBytes];

   logic                       accept;
   logic                       parsing;
   logic [15:0]                rel;
   logic [DescBytes-1:0][7:0]  dv;
   logic [7:0]                 len0;
   logic [15:0]                total_hdr;
   logic [16:0]                start_ext;
   logic [16:0]                total_ext;
   logic [16:0]                start_next;
   logic                       fail;
   rec_type                    fail_rec;
   rec_type                    desc_rec;
   rec_type                    done_rec;
   rec_type                    trunc_rec;
   logic                       emit;
   logic                       done;
   logic                       trunc;

   function automatic rec_type make_error(err_type code, logic [7:0] dtype,
                                          logic [7:0] dlen, logic [15:0] off);
      rec_type r;
      r        = '0;
      r.kind   = KIND_ERROR;
      r.code   = code;
      r.dtype  = dtype;
      r.dlen   = dlen;
      r.offset = off;
      return r;
   endfunction

   assign in_ready = !q_stat.full;
   assign accept   = in_valid & in_ready;
   assign parsing  = (phase_ff == PH_PARSE);

   assign rel       = pos_ff - start_ff;
   assign len0      = bytes_ff[0];
   assign total_hdr = {in_byte, total_ff[7:0]};
   assign start_ext = {1'b0, start_ff};
   assign total_ext = {1'b0, total_ff};
   assign start_next = start_ext + {9'd0, len0};

   // descriptor bytes as seen with the current byte merged in
   always_comb begin
      for (int i = 0; i < DescBytes; i++) begin
         dv[i] = (rel == 16'(i)) ? in_byte : bytes_ff[i];
      end
   end

   // header, length and type checks
   always_comb begin
      fail     = 1'b0;
      fail_rec = '0;
      if (pos_ff == 16'd0) begin
         if (in_blob < 16'(MinLenLong) || in_byte < MinLenLong) begin
            fail     = 1'b1;
            fail_rec = make_error(ERR_BAD_HEADER, 8'd0, 8'd0, pos_ff);
         end
      end else if (pos_ff == 16'd1) begin
         if (in_byte != DT_CONFIG) begin
            fail     = 1'b1;
            fail_rec = make_error(ERR_BAD_HEADER, 8'd0, 8'd0, pos_ff);
         end
      end else if (pos_ff == 16'd2) begin
         fail = 1'b0;
      end else if (pos_ff == 16'd3) begin
         if (total_hdr < 16'(MinLenLong) || total_hdr > in_blob) begin
            fail     = 1'b1;
            fail_rec = make_error(ERR_TRUNCATED, 8'd0, 8'd0, pos_ff);
         end else if ({8'd0, len0} > total_hdr) begin
            fail     = 1'b1;
            fail_rec = make_error(ERR_BAD_LENGTH, bytes_ff[1], len0, 16'd0);
         end
      end else if (rel == 16'd0) begin
         if (start_ext + 17'd2 > total_ext || in_byte < MinLenAny ||
             start_ext + {9'd0, in_byte} > total_ext) begin
            fail     = 1'b1;
            fail_rec = make_error(ERR_BAD_LENGTH, 8'd0, in_byte, start_ff);
         end
      end else if (rel == 16'd1) begin
         if ((in_byte inside {DT_CONFIG, DT_INTERFACE} && len0 < MinLenLong) ||
             (in_byte == DT_ENDPOINT && len0 < MinLenEndpoint)) begin
            fail     = 1'b1;
            fail_rec = make_error(ERR_TOO_SHORT, in_byte, len0, start_ff);
         end
      end
   end

   // decode of a complete descriptor
   always_comb begin
      desc_rec        = '0;
      desc_rec.dtype  = dv[1];
      desc_rec.dlen   = dv[0];
      desc_rec.offset = start_ff;
      case (dv[1])
         DT_CONFIG: begin
            desc_rec.kind  = KIND_CONFIG;
            desc_rec.val_a = dv[5];
            desc_rec.val_b = dv[4];
            desc_rec.val_c = {8'd0, dv[8]};
            desc_rec.val_d = dv[7] & SelfPoweredBit;
         end
         DT_INTERFACE: begin
            desc_rec.kind  = KIND_INTERFACE;
            desc_rec.val_a = dv[2];
            desc_rec.val_b = dv[3];
            desc_rec.val_c = {8'd0, dv[4]};
            desc_rec.val_d = dv[5];
            desc_rec.val_e = dv[6];
         end
         DT_ENDPOINT: begin
            desc_rec.kind   = KIND_ENDPOINT;
            desc_rec.val_a  = dv[2];
            desc_rec.val_b  = dv[3] & XferTypeMask;
            desc_rec.val_c  = {dv[5], dv[4]};
            desc_rec.val_d  = dv[6];
            desc_rec.dir_in = dv[2][7];
         end
         default: begin
            desc_rec.kind = KIND_OTHER;
         end
      endcase
   end

   // end of descriptor, end of chain, early end of blob
   assign emit  = !fail && (pos_ff >= 16'd4) && (rel != 16'd0) &&
                  ({1'b0, rel} + 17'd1 == {9'd0, len0});
   assign done  = emit && (start_next >= total_ext);
   assign trunc = in_last && !fail && !done;

   always_comb begin
      done_rec         = '0;
      done_rec.kind    = KIND_DONE;
      done_rec.offset  = total_ff;
      trunc_rec        = make_error(ERR_TRUNCATED, 8'd0, 8'd0, pos_ff);
   end

   // record pair toward the queue
   always_comb begin
      push_pair.two    = emit && (done || trunc);
      push_pair.first  = fail ? fail_rec : (emit ? desc_rec : trunc_rec);
      push_pair.second = done ? done_rec : trunc_rec;
   end
   assign push = accept && parsing && (fail || emit || in_last);

   // next parser state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      start_in = start_ff;
      if (accept) begin
         if (parsing) begin
            pos_in = pos_ff + 16'd1;
            if (pos_ff == 16'd2) begin
               total_in = {8'd0, in_byte};
            end else if (pos_ff == 16'd3) begin
               total_in = total_hdr;
            end
            if (emit) begin
               start_in = start_next[15:0];
            end
            if (fail || done) begin
               phase_in = PH_IDLE;
            end
         end
         if (in_last) begin
            phase_in = PH_PARSE;
            pos_in   = 16'd0;
            total_in = 16'd0;
            start_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PARSE;
         pos_ff   <= 16'd0;
         total_ff <= 16'd0;
         start_ff <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         start_ff <= start_in;
      end
   end

   // first bytes of the current descriptor, no reset needed
   always_ff @(posedge clock) begin
      if (accept && parsing && rel < 16'(DescBytes)) begin
         bytes_ff[rel[3:0]] <= in_byte;
      end
   end

endmodule

>>> rtl/core/ucdp_queue.sv
// Short record-pair queue between the parser front and the output stage.
// Depends on ucdp_pkg.
module ucdp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ucdp_pkg::pair_type  push_pair,
   input  logic                pop,
   output ucdp_pkg::pair_type  head,
   output ucdp_pkg::qstat_type stat
);
   import ucdp_pkg::*;

   pair_type               slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ff, wr_in;
   logic [QueuePtrW-1:0]   rd_ff, rd_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign stat.full  = (count_ff == QueueCntW'(QueueDepth));
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;
   assign head       = slot_ff[rd_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   // pointers and fill count
   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_pair;
      end
   end

endmodule

>>> rtl/core/ucdp_back.sv
// Output stage: takes record pairs from the queue and presents them one
// word at a time in an output register. Depends on ucdp_pkg.
module ucdp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  ucdp_pkg::pair_type head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output ucdp_pkg::rec_type  out_rec,
   output logic               out_last
);
   import ucdp_pkg::*;

   pair_type cur_ff;
   logic     valid_ff;
   logic     second_ff;
   logic     slot_free;

   assign out_valid = valid_ff;
   assign out_rec   = second_ff ? cur_ff.second : cur_ff.first;
   assign out_last  = second_ff || !cur_ff.two;

   // register frees when empty or when its final word goes out
   assign slot_free = !valid_ff || (out_ready && out_last);
   assign pop       = slot_free && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (valid_ff && out_ready && !out_last) begin
         second_ff <= 1'b1;
      end else if (slot_free) begin
         valid_ff  <= !q_empty;
         second_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

endmodule

>>> verif/usb_config_descriptor_record_checker.sv
// Record checker for the USB configuration descriptor parser.
// Watches the req and rsp streams, predicts the decoded records of every accepted
// byte and compares them in order. Depends on ucdp_pkg.
`timescale 1ns / 1ps

module usb_config_descriptor_record_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // [7:0] data_byte, [23:8] blob_length
   input  logic [ucdp_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] error_code, [10:3] desc_type, [18:11] desc_length, [34:19] desc_offset,
   // [42:35] value_a, [50:43] value_b, [66:51] value_c, [74:67] value_d,
   // [82:75] value_e, [83] direction_in, [87:84] zero
   input  logic [ucdp_pkg::RspDataW-1:0] rsp_tdata,
   // [2:0] record_kind
   input  logic [2:0]                    rsp_tuser,
   input  logic                          rsp_tlast,
   output int                            mismatches,
   output int                            pending
);
   import ucdp_pkg::*;

   localparam logic [7:0] DirInBit = 8'h80;

   typedef struct packed {
      rec_type rec;
      logic    tail;
   } awaited_type;

   // parser state as the block should hold it
   logic [15:0] byte_pos;
   logic [15:0] total_len;
   logic [15:0] desc_start;
   logic [7:0]  desc_buf [DescBytes];
   logic        parsing;

   rec_type     step_records[$];
   awaited_type awaited_records[$];

   task automatic add_record(input kind_type kind, input err_type code,
                             input logic [7:0] dtype, input logic [7:0] dlen,
                             input logic [15:0] offset, input logic [7:0] a,
                             input logic [7:0] b, input logic [15:0] c,
                             input logic [7:0] d, input logic [7:0] e,
                             input logic dir_in);
      rec_type r;
      r.kind   = kind;
      r.code   = code;
      r.dtype  = dtype;
      r.dlen   = dlen;
      r.offset = offset;
      r.val_a  = a;
      r.val_b  = b;
      r.val_c  = c;
      r.val_d  = d;
      r.val_e  = e;
      r.dir_in = dir_in;
      step_records.insert(step_records.size(), r);
   endtask

   // an error record stops parsing until the end of the blob
   task automatic report_fault(input err_type code, input logic [7:0] dtype,
                               input logic [7:0] dlen, input logic [15:0] offset);
      add_record(KIND_ERROR, code, dtype, dlen, offset, 8'h00, 8'h00, 16'h0000,
                 8'h00, 8'h00, 1'b0);
      parsing = 1'b0;
   endtask

   // decode the descriptor that just completed
   task automatic decode_descriptor();
      case (desc_buf[1])
         DT_CONFIG:
            add_record(KIND_CONFIG, ERR_NONE, desc_buf[1], desc_buf[0], desc_start,
                       desc_buf[5], desc_buf[4], {8'h00, desc_buf[8]},
                       desc_buf[7] & SelfPoweredBit, 8'h00, 1'b0);
         DT_INTERFACE:
            add_record(KIND_INTERFACE, ERR_NONE, desc_buf[1], desc_buf[0], desc_start,
                       desc_buf[2], desc_buf[3], {8'h00, desc_buf[4]},
                       desc_buf[5], desc_buf[6], 1'b0);
         DT_ENDPOINT:
            add_record(KIND_ENDPOINT, ERR_NONE, desc_buf[1], desc_buf[0], desc_start,
                       desc_buf[2], desc_buf[3] & XferTypeMask,
                       {desc_buf[5], desc_buf[4]}, desc_buf[6], 8'h00,
                       (desc_buf[2] & DirInBit) != 8'h00);
         default:
            add_record(KIND_OTHER, ERR_NONE, desc_buf[1], desc_buf[0], desc_start,
                       8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
      endcase
   endtask

   // advance the parser by one blob byte and queue the records it causes
   task automatic parse_blob_byte(input logic [7:0] data, input logic [15:0] blob,
                                  input logic last);
      int unsigned pos;
      int unsigned start;
      int unsigned total;
      int unsigned rel;
      awaited_type entry;
      step_records.delete();
      if (parsing) begin
         pos   = byte_pos;
         start = desc_start;
         total = total_len;
         rel   = pos - start;
         if (rel < DescBytes) desc_buf[rel] = data;

         // header bytes, then length and type bytes of later descriptors
         if (pos == 0) begin
            if (blob < MinLenLong || data < MinLenLong)
               report_fault(ERR_BAD_HEADER, 8'h00, 8'h00, pos[15:0]);
         end else if (pos == 1) begin
            if (data != DT_CONFIG) report_fault(ERR_BAD_HEADER, 8'h00, 8'h00, pos[15:0]);
         end else if (pos == 2) begin
            total_len = {8'h00, data};
         end else if (pos == 3) begin
            total     = {data, total_len[7:0]};
            total_len = total[15:0];
            if (total < MinLenLong || total > blob)
               report_fault(ERR_TRUNCATED, 8'h00, 8'h00, pos[15:0]);
            else if (desc_buf[0] > total)
               report_fault(ERR_BAD_LENGTH, desc_buf[1], desc_buf[0], 16'h0000);
         end else if (rel == 0) begin
            if (start + MinLenAny > total || data < MinLenAny || start + data > total)
               report_fault(ERR_BAD_LENGTH, 8'h00, data, start[15:0]);
         end else if (rel == 1) begin
            if (((data == DT_CONFIG || data == DT_INTERFACE) && desc_buf[0] < MinLenLong) ||
                (data == DT_ENDPOINT && desc_buf[0] < MinLenEndpoint))
               report_fault(ERR_TOO_SHORT, data, desc_buf[0], start[15:0]);
         end

         // descriptor complete: record, then done when the total is reached
         if (parsing && pos >= 4 && rel >= 1 && rel + 1 == desc_buf[0]) begin
            decode_descriptor();
            start      = start + desc_buf[0];
            desc_start = start[15:0];
            if (start >= total) begin
               add_record(KIND_DONE, ERR_NONE, 8'h00, 8'h00, total[15:0], 8'h00, 8'h00,
                          16'h0000, 8'h00, 8'h00, 1'b0);
               parsing = 1'b0;
            end
         end

         if (last && parsing) report_fault(ERR_TRUNCATED, 8'h00, 8'h00, pos[15:0]);
         byte_pos = pos[15:0] + 16'd1;
      end

      if (last) begin
         byte_pos   = '0;
         total_len  = '0;
         desc_start = '0;
         parsing    = 1'b1;
      end

      foreach (step_records[i]) begin
         entry.rec  = step_records[i];
         entry.tail = (i == step_records.size() - 1);
         awaited_records.insert(awaited_records.size(), entry);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // compare one rsp word with the oldest expected record
   task automatic check_record_word();
      awaited_type want;
      if (awaited_records.size() == 0) begin
         $display("%0t ns: unexpected rsp word, expected none, got kind %0d data 0x%0h",
                  $time, rsp_tuser, rsp_tdata);
         mismatches++;
      end else begin
         want = awaited_records.pop_front();
         compare_field("record_kind", 16'(want.rec.kind), 16'(rsp_tuser));
         compare_field("error_code", 16'(want.rec.code), 16'(rsp_tdata[2:0]));
         compare_field("desc_type", 16'(want.rec.dtype), 16'(rsp_tdata[10:3]));
         compare_field("desc_length", 16'(want.rec.dlen), 16'(rsp_tdata[18:11]));
         compare_field("desc_offset", want.rec.offset, rsp_tdata[34:19]);
         compare_field("value_a", 16'(want.rec.val_a), 16'(rsp_tdata[42:35]));
         compare_field("value_b", 16'(want.rec.val_b), 16'(rsp_tdata[50:43]));
         compare_field("value_c", want.rec.val_c, rsp_tdata[66:51]);
         compare_field("value_d", 16'(want.rec.val_d), 16'(rsp_tdata[74:67]));
         compare_field("value_e", 16'(want.rec.val_e), 16'(rsp_tdata[82:75]));
         compare_field("direction_in", 16'(want.rec.dir_in), 16'(rsp_tdata[83]));
         compare_field("tdata padding", 16'h0000, 16'(rsp_tdata[87:84]));
         compare_field("last_of_run", 16'(want.tail), 16'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_pos   = '0;
         total_len  = '0;
         desc_start = '0;
         parsing    = 1'b1;
         foreach (desc_buf[i]) desc_buf[i] = 8'h00;
         awaited_records.delete();
         mismatches = 0;
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready)
            parse_blob_byte(req_tdata[7:0], req_tdata[23:8], req_tlast);
         if (rsp_tvalid && rsp_tready) check_record_word();
         pending <= awaited_records.size();
      end
   end

endmodule

>>> verif/usb_config_descriptor_parser_test.sv
// Testbench top for usb_config_descriptor_parser: clock, reset, blob stimulus,
// rsp back-pressure and the verdict. Depends on ucdp_pkg, the parser RTL and
// usb_config_descriptor_record_checker.
`timescale 1ns / 1ps

module usb_config_descriptor_parser_test;
   import ucdp_pkg::*;

   localparam int RandomBytes = 1550;
   localparam int CycleLimit  = 400000;
   localparam int SettleWait  = 20;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [2:0]          rsp_tuser;
   logic                rsp_tlast;

   int mismatches;
   int pending;
   int idle_pct  = 11;
   int stall_pct = 85;
   int sent_bytes = 0;
   int cycle_count = 0;

   // blob under construction and its length tag
   logic [7:0]  blob_bytes[$];
   logic [15:0] blob_tag;

   usb_config_descriptor_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   usb_config_descriptor_record_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   // rsp back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // push the current blob, one word per byte, tlast on the final one
   task automatic send_blob();
      for (int i = 0; i < blob_bytes.size(); i++) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {blob_tag, blob_bytes[i]};
         req_tlast  <= (i == blob_bytes.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent_bytes++;
      end
   endtask

   // hold off the sender until every expected record has come out
   task automatic drain_records();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mostly well-formed blobs with random content, some damaged, some noise
   task automatic build_random_blob();
      int unsigned pick;
      int unsigned len;
      int unsigned total;
      int unsigned spot;
      int unsigned starts[$];
      logic [7:0]  dtype;
      blob_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         len = $urandom_range(1, 12);
         repeat (len) blob_bytes.insert(blob_bytes.size(), 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) begin
            blob_bytes[0] = 8'($urandom_range(9, 255));
            if (len > 1) blob_bytes[1] = DT_CONFIG;
         end
         blob_tag = 16'($urandom_range(0, 65535));
         return;
      end

      // configuration header, total filled in below
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : 9;
      starts.insert(starts.size(), 0);
      blob_bytes.insert(blob_bytes.size(), len[7:0]);
      blob_bytes.insert(blob_bytes.size(), DT_CONFIG);
      repeat (len - 2) blob_bytes.insert(blob_bytes.size(), 8'($urandom_range(0, 255)));

      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 3))
            0: begin
               len   = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : 9;
               dtype = DT_INTERFACE;
            end
            1, 2: begin
               len   = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10) : 7;
               dtype = DT_ENDPOINT;
            end
            default: begin
               len   = $urandom_range(2, 12);
               dtype = 8'($urandom_range(0, 255));
               if ((dtype == DT_CONFIG || dtype == DT_INTERFACE) && len < MinLenLong) len = 9;
               if (dtype == DT_ENDPOINT && len < MinLenEndpoint) len = 7;
            end
         endcase
         starts.insert(starts.size(), blob_bytes.size());
         blob_bytes.insert(blob_bytes.size(), len[7:0]);
         blob_bytes.insert(blob_bytes.size(), dtype);
         repeat (len - 2) blob_bytes.insert(blob_bytes.size(), 8'($urandom_range(0, 255)));
      end
      total = blob_bytes.size();
      blob_bytes[2] = total[7:0];
      blob_bytes[3] = total[15:8];
      blob_tag = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(total, 65535))
                                              : 16'(total + $urandom_range(0, 2));
      repeat ($urandom_range(0, 2))
         blob_bytes.insert(blob_bytes.size(), 8'($urandom_range(0, 255)));

      // damage some blobs
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         spot = $urandom_range(0, blob_bytes.size() - 1);
         blob_bytes[spot] = 8'($urandom_range(0, 255));
      end else if (pick < 16) begin
         len = $urandom_range(1, blob_bytes.size() - 1);
         while (blob_bytes.size() > len) void'(blob_bytes.pop_back());
      end else if (pick < 20) begin
         blob_tag = 16'($urandom_range(0, total - 1));
      end else if (pick < 26) begin
         spot = starts[$urandom_range(0, starts.size() - 1)];
         blob_bytes[spot] = 8'($urandom_range(0, 12));
      end else if (pick < 32) begin
         spot = starts[$urandom_range(0, starts.size() - 1)] + 1;
         case ($urandom_range(0, 2))
            0:       blob_bytes[spot] = DT_CONFIG;
            1:       blob_bytes[spot] = DT_INTERFACE;
            default: blob_bytes[spot] = DT_ENDPOINT;
         endcase
      end
   endtask

   // run limit
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // header rejected: blob tag under 9
      blob_bytes = '{8'd9};
      blob_tag   = 16'd0;
      send_blob();
      // header rejected: header length under 9
      blob_bytes = '{8'd8};
      blob_tag   = 16'hFFFF;
      send_blob();
      // header rejected: wrong type
      blob_bytes = '{8'hFF, 8'd3};
      blob_tag   = 16'hFFFF;
      send_blob();
      // total under 9
      blob_bytes = '{8'd9, DT_CONFIG, 8'd8, 8'd0};
      blob_tag   = 16'd9;
      send_blob();
      // total past the blob
      blob_bytes = '{8'd9, DT_CONFIG, 8'd10, 8'd0};
      blob_tag   = 16'd9;
      send_blob();
      // first descriptor longer than the total
      blob_bytes = '{8'h20, DT_CONFIG, 8'd9, 8'd0};
      blob_tag   = 16'd9;
      send_blob();
      // smallest valid blob, configuration and done on one byte
      blob_bytes = '{8'd9, DT_CONFIG, 8'd9, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      blob_tag   = 16'd9;
      send_blob();
      drain_records();

      // random blobs under three idle patterns
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 11;
               stall_pct = 85;
            end
            1: begin
               idle_pct  = 85;
               stall_pct = 11;
            end
            default: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
         endcase
         phase_end = sent_bytes + RandomBytes / 3;
         while (sent_bytes < phase_end) begin
            build_random_blob();
            send_blob();
         end
         drain_records();
      end

      repeat (SettleWait) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/ucdp_pkg.sv
rtl/core/ucdp_front.sv
rtl/core/ucdp_queue.sv
rtl/core/ucdp_back.sv
rtl/core/usb_config_descriptor_parser.sv
verif/usb_config_descriptor_record_checker.sv
verif/usb_config_descriptor_parser_test.sv
